>>> sv/shape_vertex_generator_macros.svh
// assertion macros for the shape vertex generator
// used by shape_vertex_generator.sv, expects aclk and aresetn in scope
`ifndef SHAPE_VERTEX_GENERATOR_MACROS_SVH
`define SHAPE_VERTEX_GENERATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SVG_ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SVG_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) else $error(msg);

`endif

>>> sv/svg_pkg.sv
// shared types, constants and tables for the shape vertex generator
// no dependencies
package svg_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int CW               = 33;
    localparam logic signed [CW-1:0] KGAIN_Q30 = 33'sd652032874;

    typedef enum logic [2:0] {
        OP_CIRCLE  = 3'd0,
        OP_POLYGON = 3'd1,
        OP_STAR    = 3'd2,
        OP_SPIRAL  = 3'd3,
        OP_WAVE    = 3'd4
    } op_t;

    // atan(2^-k) in turns, full turn is 2^32
    function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] k);
        logic signed [CW-1:0] v;
        case (k)
            5'd0:  v = 33'sd536870912;
            5'd1:  v = 33'sd316933406;
            5'd2:  v = 33'sd167458907;
            5'd3:  v = 33'sd85004756;
            5'd4:  v = 33'sd42667331;
            5'd5:  v = 33'sd21354465;
            5'd6:  v = 33'sd10679838;
            5'd7:  v = 33'sd5340245;
            5'd8:  v = 33'sd2670163;
            5'd9:  v = 33'sd1335087;
            5'd10: v = 33'sd667544;
            5'd11: v = 33'sd333772;
            5'd12: v = 33'sd166886;
            5'd13: v = 33'sd83443;
            5'd14: v = 33'sd41722;
            5'd15: v = 33'sd20861;
            5'd16: v = 33'sd10430;
            5'd17: v = 33'sd5215;
            5'd18: v = 33'sd2608;
            5'd19: v = 33'sd1304;
            5'd20: v = 33'sd652;
            5'd21: v = 33'sd326;
            5'd22: v = 33'sd163;
            5'd23: v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/shape_vertex_generator.sv
// shape vertex generator top level: sequencer, serial divider, cordic, multiplier
// depends on svg_pkg and shape_vertex_generator_macros.svh
//
// One request produces all vertices of a shape; s_tready is low until the last
// vertex has been taken. Each vertex runs through a restoring divider that
// loads its numerator and then retires one quotient bit per cycle (one
// division for circle, polygon and star, three for spiral and wave), then
// CORDIC_STEPS rotation steps plus a quadrant fold, then the x and y products
// on one shared multiplier, then the output register, which holds the vertex
// until m_tready.
`include "shape_vertex_generator_macros.svh"

module shape_vertex_generator #(
    parameter int MAX_VERTICES = svg_pkg::MAX_VERTICES_DEF,
    parameter int CORDIC_STEPS = svg_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, count, radius, inner_radius, center_x, center_y, turns, amplitude, frequency
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, tex_u, tex_v
    output logic [63:0]  m_tdata,
    output logic         m_tlast
);

    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int NUM_W = IW + 40;
    localparam int CW    = svg_pkg::CW;
    localparam int PW    = CW + 17;
    localparam logic [7:0] LIM_CIRC = 8'(MAX_VERTICES - 1);
    localparam logic [7:0] LIM_STAR = 8'((MAX_VERTICES - 1) / 2);
    localparam logic [7:0] LIM_N    = 8'(MAX_VERTICES);
    localparam logic [4:0] STEPS    = 5'(CORDIC_STEPS);
    localparam logic [6:0] DIV_BITS = 7'(NUM_W);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_CORD = 7'b0000100,
        ST_MULX = 7'b0001000,
        ST_MULY = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    svg_pkg::op_t op_reg;
    logic [IW-1:0] i_reg, last_reg;
    logic [15:0] radius_reg, inner_reg, amp_reg, freq_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic [3:0] turns_reg;
    logic [1:0] job_reg;
    logic [IW-1:0] rem_reg;
    logic [NUM_W-1:0] nq_reg;
    logic [6:0] bit_reg;
    logic [31:0] phase_reg;
    logic [15:0] aux_reg, t_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg, co_reg, si_reg;
    logic [4:0] k_reg;
    logic signed [PW-1:0] prod_reg;
    logic [15:0] px_reg;
    logic [63:0] tdata_reg;
    logic valid_reg, tlast_reg;

    // request decode
    logic [2:0] in_op;
    logic [7:0] in_cnt, cl_circ, cl_star, cl_n;
    svg_pkg::op_t op_next;
    logic [IW-1:0] last_next;

    always_comb begin
        in_op  = s_tdata[2:0];
        in_cnt = {1'b0, s_tdata[9:3]};
        cl_circ = (in_cnt < 8'd1) ? 8'd1 : (in_cnt > LIM_CIRC) ? LIM_CIRC : in_cnt;
        cl_star = (in_cnt < 8'd1) ? 8'd1 : (in_cnt > LIM_STAR) ? LIM_STAR : in_cnt;
        cl_n    = (in_cnt < 8'd2) ? 8'd2 : (in_cnt > LIM_N) ? LIM_N : in_cnt;
        op_next = (in_op > 3'd4) ? svg_pkg::OP_CIRCLE : svg_pkg::op_t'(in_op);
        case (op_next)
            svg_pkg::OP_STAR:   last_next = IW'({cl_star, 1'b0});
            svg_pkg::OP_SPIRAL,
            svg_pkg::OP_WAVE:   last_next = IW'(cl_n - 8'd1);
            default:            last_next = IW'(cl_circ);
        endcase
    end

    logic is_radial;
    assign is_radial = (op_reg == svg_pkg::OP_CIRCLE) || (op_reg == svg_pkg::OP_POLYGON)
                    || (op_reg == svg_pkg::OP_STAR);

    // division numerators
    logic [IW-1:0] hdiv;
    logic [NUM_W-1:0] num_sel;
    logic [IW+3:0] it_prod;
    logic [IW+15:0] fi_prod, ri_prod;

    always_comb begin
        hdiv    = last_reg >> 1;
        it_prod = (IW+4)'(i_reg) * (IW+4)'(turns_reg);
        fi_prod = (IW+16)'(i_reg) * (IW+16)'(freq_reg);
        ri_prod = (IW+16)'(i_reg) * (IW+16)'(radius_reg);
        case (job_reg)
            2'd0: begin
                if (op_reg == svg_pkg::OP_SPIRAL)
                    num_sel = NUM_W'({it_prod, 32'd0});
                else if (op_reg == svg_pkg::OP_WAVE)
                    num_sel = NUM_W'({fi_prod, 24'd0});
                else
                    num_sel = NUM_W'({i_reg, 32'd0});
            end
            2'd1: begin
                if (op_reg == svg_pkg::OP_SPIRAL)
                    num_sel = NUM_W'(ri_prod) + NUM_W'(hdiv);
                else
                    num_sel = NUM_W'({i_reg, 13'd0}) + NUM_W'(hdiv);
            end
            default: num_sel = NUM_W'({i_reg, 15'd0}) + NUM_W'(hdiv);
        endcase
    end

    // divider step
    logic [IW:0] trial;
    logic ge;
    logic [IW-1:0] rem_next;
    logic [NUM_W-1:0] nq_next;

    always_comb begin
        trial    = {rem_reg, nq_reg[NUM_W-1]};
        ge       = trial >= {1'b0, last_reg};
        rem_next = ge ? IW'(trial - {1'b0, last_reg}) : IW'(trial);
        nq_next  = {nq_reg[NUM_W-2:0], ge};
    end

    // cordic step and quadrant fold
    logic signed [CW-1:0] dx, dy, atk, c_q, s_q;

    always_comb begin
        dx  = y_reg >>> k_reg;
        dy  = x_reg >>> k_reg;
        atk = svg_pkg::atan_turn(k_reg);
        case (phase_reg[31:30])
            2'd0:    begin c_q = x_reg;  s_q = y_reg;  end
            2'd1:    begin c_q = -y_reg; s_q = x_reg;  end
            2'd2:    begin c_q = -x_reg; s_q = -y_reg; end
            default: begin c_q = y_reg;  s_q = -x_reg; end
        endcase
    end

    // shared multiplier operands
    logic [15:0] rad_sel, ay_sel;
    logic signed [16:0] mul_a;
    logic signed [CW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        if (op_reg == svg_pkg::OP_SPIRAL)
            rad_sel = aux_reg;
        else if (op_reg == svg_pkg::OP_STAR && i_reg[0])
            rad_sel = inner_reg;
        else
            rad_sel = radius_reg;
        ay_sel = (op_reg == svg_pkg::OP_WAVE) ? amp_reg : rad_sel;
        mul_a  = (state_reg == ST_MULX) ? $signed({1'b0, rad_sel}) : $signed({1'b0, ay_sel});
        mul_b  = (state_reg == ST_MULX) ? co_reg : si_reg;
        mul_p  = PW'(mul_a) * PW'(mul_b);
    end

    function automatic logic [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767)
            return 16'h7fff;
        else if (v < -21'sd32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] tex_half(input logic signed [CW-1:0] c);
        logic signed [CW:0] t;
        t = (CW+1)'(34'sd1073741824) + (CW+1)'(c) + (CW+1)'(34'sd32768);
        if (t < 0)
            return 16'd0;
        else if (t[CW:16] > (CW-15)'(32768))
            return 16'd32768;
        return t[31:16];
    endfunction

    // round half up from q42 to q12 and add the centre
    logic signed [19:0] prod_rnd;
    logic signed [PW-1:0] prod_add;
    logic signed [20:0] pos_sum, wave_x;

    always_comb begin
        prod_add = prod_reg + PW'(51'sd536870912);
        prod_rnd = prod_add[PW-1:30];
        pos_sum  = 21'(cx_reg) + 21'(prod_rnd);
        wave_x   = 21'(cx_reg) - 21'sd4096 + $signed({5'd0, aux_reg});
        if (state_reg == ST_FIN)
            pos_sum = 21'(cy_reg) + 21'(prod_rnd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= op_next;
                        last_reg   <= last_next;
                        radius_reg <= s_tdata[25:10];
                        inner_reg  <= s_tdata[41:26];
                        cx_reg     <= s_tdata[57:42];
                        cy_reg     <= s_tdata[73:58];
                        turns_reg  <= s_tdata[77:74];
                        amp_reg    <= s_tdata[93:78];
                        freq_reg   <= s_tdata[109:94];
                        i_reg      <= '0;
                        job_reg    <= 2'd0;
                        bit_reg    <= '0;
                        state_reg  <= ST_DIV;
                        rem_reg    <= '0;
                        nq_reg     <= '1;
                    end
                end
                ST_DIV: begin
                    if (bit_reg == 7'd0 && nq_reg == '1 && rem_reg == '0) begin
                        nq_reg  <= num_sel;
                        bit_reg <= 7'd1;
                    end else if (bit_reg == 7'd0) begin
                        nq_reg  <= num_sel;
                        bit_reg <= 7'd1;
                    end else begin
                        nq_reg  <= nq_next;
                        if (bit_reg == DIV_BITS) begin
                            bit_reg <= '0;
                            rem_reg <= '0;
                            case (job_reg)
                                2'd0:    phase_reg <= nq_next[31:0];
                                2'd1:    aux_reg   <= nq_next[15:0];
                                default: t_reg     <= nq_next[15:0];
                            endcase
                            if (is_radial || job_reg == 2'd2) begin
                                state_reg <= ST_CORD;
                                x_reg     <= svg_pkg::KGAIN_Q30;
                                y_reg     <= '0;
                                z_reg     <= (job_reg == 2'd0)
                                    ? $signed({3'd0, nq_next[29:0]})
                                    : $signed({3'd0, phase_reg[29:0]});
                                k_reg     <= '0;
                            end else begin
                                job_reg <= job_reg + 2'd1;
                            end
                        end else begin
                            rem_reg <= rem_next;
                            bit_reg <= bit_reg + 7'd1;
                        end
                    end
                end
                ST_CORD: begin
                    if (k_reg == STEPS || k_reg == 5'(svg_pkg::ATAN_LEN)) begin
                        co_reg    <= c_q;
                        si_reg    <= s_q;
                        state_reg <= ST_MULX;
                    end else begin
                        if (!z_reg[CW-1]) begin
                            x_reg <= x_reg - dx;
                            y_reg <= y_reg + dy;
                            z_reg <= z_reg - atk;
                        end else begin
                            x_reg <= x_reg + dx;
                            y_reg <= y_reg - dy;
                            z_reg <= z_reg + atk;
                        end
                        k_reg <= k_reg + 5'd1;
                    end
                end
                ST_MULX: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MULY;
                end
                ST_MULY: begin
                    px_reg    <= (op_reg == svg_pkg::OP_WAVE) ? sat16(wave_x) : sat16(pos_sum);
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    tdata_reg[15:0]  <= px_reg;
                    tdata_reg[31:16] <= sat16(pos_sum);
                    if (is_radial) begin
                        tdata_reg[47:32] <= tex_half(co_reg);
                        tdata_reg[63:48] <= tex_half(si_reg);
                    end else begin
                        tdata_reg[47:32] <= t_reg;
                        tdata_reg[63:48] <= (op_reg == svg_pkg::OP_SPIRAL) ? 16'd16384
                                                                           : tex_half(si_reg);
                    end
                    tlast_reg <= (i_reg == last_reg);
                    valid_reg <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        valid_reg <= 1'b0;
                        if (tlast_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg     <= i_reg + IW'(1);
                            job_reg   <= 2'd0;
                            bit_reg   <= '0;
                            rem_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    `SVG_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready, "request taken while a vertex is pending")
    `SVG_ASSERT_NEXT(a_done_idle, m_tvalid && m_tready && m_tlast, s_tready, "not idle after last vertex")
    `SVG_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready && !m_tvalid, "request not held busy")
    `SVG_ASSERT_SAME(a_out_state, m_tvalid, state_reg == ST_OUT, "vertex valid outside output state")

endmodule
